@@ sv/ivi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ivi_pkg;

  localparam int unsigned CompW   = 32;
  localparam int unsigned MagW    = 33;   // component magnitude up to 2^32
  localparam int unsigned SqW     = 66;   // sum of three squares of 32-bit magnitudes
  localparam int unsigned LenW    = 33;   // root of SqW plus one doubling
  localparam int unsigned DivW    = 64;   // dividend |c|*s
  localparam int unsigned QuoW    = 34;   // quotient bound: s <= len, so |c|*s/len <= |c|
  localparam int unsigned NumLanes = 3;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_IMPULSE = 2'd1,
    OP_STEER   = 2'd2,
    OP_SET     = 2'd3
  } op_t;

  localparam logic CFG_DECEL   = 1'b0;
  localparam logic CFG_MINFORCE = 1'b1;

  typedef struct packed {
    logic start;
    logic [LenW-1:0] scale;
    logic [LenW-1:0] len;
  } lane_ctl_t;

  function automatic logic signed [CompW-1:0] sat32(input logic signed [CompW+1:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[CompW-1:0];
  endfunction

  function automatic logic [MagW-1:0] mag(input logic signed [MagW:0] v);
    logic signed [MagW:0] n;
    n = -v;
    return v[MagW] ? n[MagW-1:0] : v[MagW-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/ivi_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface ivi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] dt;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [30:0] accel_rate;
  modport source(output valid, op, dt, vec_x, vec_y, vec_z, accel_rate, input ready);
  modport sink(input valid, op, dt, vec_x, vec_y, vec_z, accel_rate, output ready);
endinterface

interface ivi_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_dx;
  logic signed [31:0] pos_dy;
  logic signed [31:0] pos_dz;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  modport source(output valid, pos_dx, pos_dy, pos_dz, vel_x, vel_y, vel_z, input ready);
  modport sink(input valid, pos_dx, pos_dy, pos_dz, vel_x, vel_y, vel_z, output ready);
endinterface
`default_nettype wire

@@ sv/ivi_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared vector length unit: squares one magnitude per cycle, then a
// restoring root two bits per cycle.
module ivi_sqrt import ivi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [MagW-1:0] m0,
  input  wire logic [MagW-1:0] m1,
  input  wire logic [MagW-1:0] m2,
  output logic      done,
  output logic [LenW-1:0] len
);
  localparam int unsigned RootSteps = SqW / 2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ   = 4'b0010,
    S_ROOT = 4'b0100,
    S_DONE = 4'b1000
  } sq_state_t;

  sq_state_t state_r, state_nxt;
  logic [1:0] sq_cnt_r, sq_cnt_nxt;
  logic [5:0] rt_cnt_r, rt_cnt_nxt;
  logic sh_r, sh_nxt;
  logic [MagW-1:0] m_r [NumLanes];
  logic [SqW-1:0] sum_r, sum_nxt;
  logic [SqW-1:0] rem_r, rem_nxt;
  logic [SqW-1:0] root_r, root_nxt;
  logic [SqW-1:0] bit_r, bit_nxt;
  logic [31:0] a;
  logic [63:0] sq;
  logic [MagW-1:0] msel;

  always_comb begin
    case (sq_cnt_r)
      2'd0:    msel = m_r[0];
      2'd1:    msel = m_r[1];
      default: msel = m_r[2];
    endcase
    a  = sh_r ? msel[32:1] : msel[31:0];
    sq = a * a;
  end

  always_comb begin
    logic [SqW-1:0] t;
    state_nxt  = state_r;
    sq_cnt_nxt = sq_cnt_r;
    rt_cnt_nxt = rt_cnt_r;
    sh_nxt     = sh_r;
    sum_nxt    = sum_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    bit_nxt    = bit_r;
    t          = root_r + bit_r;
    case (state_r)
      S_IDLE: if (start) begin
        state_nxt  = S_SQ;
        sq_cnt_nxt = 2'd0;
        sum_nxt    = '0;
        sh_nxt     = (m0 > 33'h080000000) | (m1 > 33'h080000000) | (m2 > 33'h080000000);
      end
      S_SQ: begin
        sum_nxt = sum_r + SqW'(sq);
        if (sq_cnt_r == 2'd2) begin
          state_nxt  = S_ROOT;
          rt_cnt_nxt = '0;
          root_nxt   = '0;
          bit_nxt    = SqW'(1) << (SqW - 2);
        end else begin
          sq_cnt_nxt = sq_cnt_r + 2'd1;
        end
      end
      S_ROOT: begin
        if (rt_cnt_r == 6'd0) rem_nxt = sum_r;
        if (rt_cnt_r != 6'd0 || 1'b1) begin
          if ((rt_cnt_r == 6'd0 ? sum_r : rem_r) >= t) begin
            rem_nxt  = (rt_cnt_r == 6'd0 ? sum_r : rem_r) - t;
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
        end
        bit_nxt    = bit_r >> 2;
        rt_cnt_nxt = rt_cnt_r + 6'd1;
        if (rt_cnt_r == 6'(RootSteps - 1)) state_nxt = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sq_cnt_r <= sq_cnt_nxt;
    rt_cnt_r <= rt_cnt_nxt;
    sh_r     <= sh_nxt;
    sum_r    <= sum_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    bit_r    <= bit_nxt;
    if (state_r == S_IDLE && start) begin
      m_r[0] <= m0;
      m_r[1] <= m1;
      m_r[2] <= m2;
    end
  end

  assign done = (state_r == S_DONE);
  assign len  = sh_r ? {root_r[LenW-2:0], 1'b0} : root_r[LenW-1:0];
endmodule
`default_nettype wire

@@ sv/ivi_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One component lane: sign(c) * floor(|c| * scale / len), a bit per cycle.
module ivi_lane import ivi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire lane_ctl_t ctl,
  input  wire logic signed [MagW:0] comp,
  output logic done,
  output logic signed [QuoW:0] result
);
  logic busy_r;
  logic [6:0] cnt_r;
  logic neg_r;
  logic [DivW-1:0] num_r;
  logic [LenW-1:0] den_r;
  logic [LenW:0] rem_r;
  logic [DivW-1:0] quo_r;
  logic [MagW-1:0] m;
  logic [DivW-1:0] prod;
  logic [LenW:0] shifted;
  logic ge;

  assign m       = mag(comp);
  assign prod    = DivW'(m) * DivW'(ctl.scale);
  assign shifted = {rem_r[LenW-1:0], num_r[DivW-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DivW - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
    if (ctl.start) begin
      neg_r <= comp[MagW];
      num_r <= prod;
      den_r <= ctl.len;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= ge ? shifted - {1'b0, den_r} : shifted;
      quo_r <= {quo_r[DivW-2:0], ge};
    end
  end

  always_comb begin
    logic signed [QuoW:0] q;
    q      = $signed({1'b0, quo_r[QuoW-1:0]});
    result = neg_r ? -q : q;
  end
endmodule
`default_nettype wire

@@ sv/ivi_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: length(s), (per op) three parallel rescale lanes, merge.
module ivi_core import ivi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [30:0] decel_rate,
  input  wire logic [15:0] min_force_len,
  ivi_in_if.sink  in_ch,
  ivi_out_if.source out_ch
);
  typedef enum logic [5:0] {
    C_IDLE  = 6'b000001,
    C_LEN1  = 6'b000010,
    C_LEN2  = 6'b000100,
    C_DIV   = 6'b001000,
    C_MERGE = 6'b010000,
    C_OUT   = 6'b100000
  } core_state_t;

  core_state_t state_r;
  op_t op_r;
  logic [15:0] dt_r;
  logic [30:0] accel_r;
  logic signed [CompW-1:0] vec_r [NumLanes];
  logic signed [CompW-1:0] vel_r [NumLanes];
  logic signed [CompW-1:0] pos_r [NumLanes];
  logic signed [MagW:0] diff_r [NumLanes];
  logic [LenW-1:0] len_r, scale_r;
  logic skip_r;
  logic lane_start_r;

  logic sq_start, sq_done;
  logic [LenW-1:0] sq_len;
  logic [MagW-1:0] sm [NumLanes];
  lane_ctl_t lane_ctl;
  logic [NumLanes-1:0] lane_done;
  logic signed [QuoW:0] lane_res [NumLanes];
  logic signed [MagW:0] lane_in [NumLanes];
  logic signed [63:0] posp [NumLanes];
  logic [47:0] decp, accp;
  logic [31:0] dec, acc;

  assign decp = 48'(decel_rate) * 48'(dt_r) + 48'd32768;
  assign accp = 48'(accel_r) * 48'(dt_r) + 48'd32768;
  assign dec  = decp[47:16];
  assign acc  = accp[47:16];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      if (state_r == C_LEN2) sm[i] = mag(diff_r[i]);
      else if (op_r == OP_TICK) sm[i] = mag((MagW+1)'(vel_r[i]));
      else sm[i] = mag((MagW+1)'(vec_r[i]));
      lane_in[i] = (op_r == OP_TICK) ? (MagW+1)'(vel_r[i]) : diff_r[i];
      posp[i] = 64'(vel_r[i]) * $signed({48'd0, dt_r}) + 64'sd32768;
    end
  end

  assign in_ch.ready = (state_r == C_IDLE);
  assign sq_start = (state_r == C_LEN1 || state_r == C_LEN2) && !skip_r;

  ivi_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .m0(sm[0]), .m1(sm[1]), .m2(sm[2]), .done(sq_done), .len(sq_len)
  );

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    ivi_lane u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .comp(lane_in[g]),
      .done(lane_done[g]), .result(lane_res[g])
    );
  end

  // skip_r doubles as "start already issued" in the length states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      out_ch.valid <= 1'b0;
      lane_start_r <= 1'b0;
      for (int i = 0; i < NumLanes; i++) vel_r[i] <= '0;
    end else begin
      lane_start_r <= sq_done &&
                      ((state_r == C_LEN1 && op_r == OP_TICK && sq_len != '0) ||
                       (state_r == C_LEN2 && sq_len > LenW'(acc)));
      case (state_r)
        C_IDLE: if (in_ch.valid) begin
          op_r    <= op_t'(in_ch.op);
          dt_r    <= in_ch.dt;
          accel_r <= in_ch.accel_rate;
          vec_r[0] <= in_ch.vec_x;
          vec_r[1] <= in_ch.vec_y;
          vec_r[2] <= in_ch.vec_z;
          for (int i = 0; i < NumLanes; i++) pos_r[i] <= '0;
          skip_r  <= 1'b0;
          state_r <= (op_t'(in_ch.op) == OP_SET) ? C_MERGE : C_LEN1;
        end
        C_LEN1: begin
          skip_r <= !sq_done;
          if (sq_done) begin
            len_r  <= sq_len;
            if (op_r == OP_TICK) begin
              for (int i = 0; i < NumLanes; i++)
                pos_r[i] <= posp[i][47:16];
              scale_r <= (LenW'(sq_len) > LenW'(dec)) ? sq_len - LenW'(dec) : '0;
              if (sq_len == '0) state_r <= C_MERGE;
              else state_r <= C_DIV;
            end else if (sq_len < LenW'(min_force_len)) begin
              state_r <= C_OUT;
              out_ch.valid <= 1'b1;
            end else if (op_r == OP_IMPULSE) begin
              state_r <= C_MERGE;
            end else begin
              for (int i = 0; i < NumLanes; i++)
                diff_r[i] <= (MagW+1)'(vec_r[i]) - (MagW+1)'(vel_r[i]);
              state_r <= C_LEN2;
            end
          end
        end
        C_LEN2: begin
          skip_r <= !sq_done;
          if (sq_done) begin
            len_r   <= sq_len;
            scale_r <= LenW'(acc);
            if (sq_len > LenW'(acc)) begin
              state_r <= C_DIV;
            end else begin
              op_r    <= OP_SET;
              state_r <= C_MERGE;
            end
          end
        end
        C_DIV: if (&lane_done) state_r <= C_MERGE;
        C_MERGE: begin
          for (int i = 0; i < NumLanes; i++) begin
            case (op_r)
              OP_TICK:
                vel_r[i] <= (len_r == '0) ? '0 : sat32((CompW+2)'(lane_res[i]));
              OP_IMPULSE:
                vel_r[i] <= sat32((CompW+2)'(vel_r[i]) + (CompW+2)'(vec_r[i]));
              OP_STEER:
                vel_r[i] <= sat32((CompW+2)'(vel_r[i]) + (CompW+2)'(lane_res[i]));
              default: vel_r[i] <= vec_r[i];
            endcase
          end
          out_ch.valid <= 1'b1;
          state_r <= C_OUT;
        end
        C_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  always_comb begin
    lane_ctl.start = lane_start_r;
    lane_ctl.scale = scale_r;
    lane_ctl.len   = len_r;
  end

  assign out_ch.pos_dx = pos_r[0];
  assign out_ch.pos_dy = pos_r[1];
  assign out_ch.pos_dz = pos_r[2];
  assign out_ch.vel_x  = vel_r[0];
  assign out_ch.vel_y  = vel_r[1];
  assign out_ch.vel_z  = vel_r[2];
endmodule
`default_nettype wire

@@ sv/inertial_velocity_integrator_3d_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Inertial velocity integrator: holds a Q16.16 3D velocity and answers each
// item with one result (position delta on a tick, zero otherwise, and the
// velocity after the item). One item is in flight at a time. A set skips
// the length unit; a tick, impulse or steer runs the shared length unit
// (twice in a row for a steer) and a tick or far steer then runs three
// divider lanes in parallel; the result is held until it is taken.
// Write decel_rate (index 0) and min_force_len (index 1) only while idle.
module inertial_velocity_integrator_3d_top import ivi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_wdata,
  ivi_in_if.sink           in_ch,
  ivi_out_if.source        out_ch
);
  logic [30:0] decel_r;
  logic [15:0] minf_r;

  // hold config registers; unknown index cannot occur with a 1-bit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decel_r <= '0;
      minf_r  <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECEL:    decel_r <= cfg_wdata;
        CFG_MINFORCE: minf_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  ivi_core u_core (
    .clk(clk), .rst_n(rst_n), .decel_rate(decel_r), .min_force_len(minf_r),
    .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

@@ sv/ivi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ivi_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");
  a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
endmodule

bind inertial_velocity_integrator_3d_top ivi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
`default_nettype wire
